### hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in every cycle
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// cons must hold in the cycle in which ante holds
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rthsv_pkg.sv
package rthsv_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned HueW    = 9;
  localparam int unsigned QuotW   = 9;
  localparam int unsigned NumW    = ChW + QuotW;
  localparam int unsigned NumCells = QuotW;
  localparam int unsigned Latency = NumCells + 1;

  localparam logic [ChW-1:0]  ChMax        = 8'd255;
  localparam logic [ChW-1:0]  HueScale     = 8'd60;
  localparam logic [HueW-1:0] HueOffRedNeg = 9'd359;
  localparam logic [HueW-1:0] HueOffGreen  = 9'd119;
  localparam logic [HueW-1:0] HueOffBlue   = 9'd239;

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
  } pix_req_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [ChW-1:0]  saturation;
    logic [ChW-1:0]  brightness;
  } hsv_rsp_t;

  // one restoring divider: partial remainder, numerator bits going out at the
  // top while quotient bits come in at the bottom, divisor
  typedef struct packed {
    logic [ChW-1:0]   rem;
    logic [QuotW-1:0] sh;
    logic [ChW-1:0]   dvs;
  } div_lane_t;

  typedef struct packed {
    div_lane_t      hue;
    div_lane_t      sat;
    logic [ChW-1:0] brightness;
  } stage_t;

endpackage

### hw/rtl/rthsv_prep.sv
module rthsv_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rthsv_pkg::pix_req_t pix_i,
  output logic              valid_o,
  output rthsv_pkg::stage_t stg_o
);

  logic [rthsv_pkg::ChW-1:0]  r, g, b, mx, mn, dlt, mag;
  logic [rthsv_pkg::HueW-1:0] off;
  logic                       neg;
  logic [rthsv_pkg::NumW-1:0] off_d, mag_s, hnum, snum;
  logic [rthsv_pkg::ChW-1:0]  hdvs, sdvs;
  rthsv_pkg::stage_t          stg_d, stg_q;
  logic                       valid_q;

  always_comb begin
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    mx = (r >= g) ? r : g;
    mx = (mx >= b) ? mx : b;
    mn = (r <= g) ? r : g;
    mn = (mn <= b) ? mn : b;
    dlt = mx - mn;
  end

  always_comb begin
    off = '0;
    mag = '0;
    neg = 1'b0;
    priority if (mx == r && g >= b) begin
      mag = g - b;
    end else if (mx == r) begin
      off = rthsv_pkg::HueOffRedNeg;
      mag = b - g;
      neg = 1'b1;
    end else if (mx == g) begin
      off = rthsv_pkg::HueOffGreen;
      mag = (b >= r) ? b - r : r - b;
      neg = (b < r);
    end else begin
      off = rthsv_pkg::HueOffBlue;
      mag = (r >= g) ? r - g : g - r;
      neg = (r < g);
    end
  end

  always_comb begin
    off_d = rthsv_pkg::NumW'(off) * rthsv_pkg::NumW'(dlt);
    mag_s = rthsv_pkg::NumW'(rthsv_pkg::HueScale) * rthsv_pkg::NumW'(mag);
    if (dlt == '0) begin
      hnum = '0;
      hdvs = rthsv_pkg::ChW'(1);
    end else begin
      hnum = neg ? off_d - mag_s : off_d + mag_s;
      hdvs = dlt;
    end
    // black: quotient 255 gives saturation 0
    if (mx == '0) begin
      snum = rthsv_pkg::NumW'(rthsv_pkg::ChMax);
      sdvs = rthsv_pkg::ChW'(1);
    end else begin
      snum = rthsv_pkg::NumW'(rthsv_pkg::ChMax) * rthsv_pkg::NumW'(mn)
             + rthsv_pkg::NumW'(mx) - rthsv_pkg::NumW'(1);
      sdvs = mx;
    end
  end

  always_comb begin
    stg_d.hue.rem    = hnum[rthsv_pkg::NumW-1:rthsv_pkg::QuotW];
    stg_d.hue.sh     = hnum[rthsv_pkg::QuotW-1:0];
    stg_d.hue.dvs    = hdvs;
    stg_d.sat.rem    = snum[rthsv_pkg::NumW-1:rthsv_pkg::QuotW];
    stg_d.sat.sh     = snum[rthsv_pkg::QuotW-1:0];
    stg_d.sat.dvs    = sdvs;
    stg_d.brightness = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign valid_o = valid_q;
  assign stg_o   = stg_q;

endmodule

### hw/rtl/rthsv_div_cell.sv
module rthsv_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rthsv_pkg::stage_t stg_i,
  output logic              valid_o,
  output rthsv_pkg::stage_t stg_o
);

  function automatic rthsv_pkg::div_lane_t div_step(rthsv_pkg::div_lane_t ln);
    logic [rthsv_pkg::ChW:0] t;
    logic                    ge;
    rthsv_pkg::div_lane_t    res;
    t  = {ln.rem, ln.sh[rthsv_pkg::QuotW-1]};
    ge = (t >= {1'b0, ln.dvs});
    res.rem = ge ? rthsv_pkg::ChW'(t - {1'b0, ln.dvs}) : t[rthsv_pkg::ChW-1:0];
    res.sh  = {ln.sh[rthsv_pkg::QuotW-2:0], ge};
    res.dvs = ln.dvs;
    return res;
  endfunction

  rthsv_pkg::stage_t stg_d, stg_q;
  logic              valid_q;

  always_comb begin
    stg_d.hue        = div_step(stg_i.hue);
    stg_d.sat        = div_step(stg_i.sat);
    stg_d.brightness = stg_i.brightness;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign valid_o = valid_q;
  assign stg_o   = stg_q;

endmodule

### hw/rtl/rgb_to_hsv_pixel_unit.sv
// Channel   Direction  Marker    Payload
// request   in         start     req_i  (red_in, green_in, blue_in)
// result    out        done_o    rsp_o  (hue, saturation, brightness)
//
// One request per clock; busy stays low. Each result passes through the prep
// register for max/min and numerators, then a row of nine restoring-divide cells,
// one quotient bit per cell, both divisions sharing each cell.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// Results are shown for one cycle on done_o; the receiver cannot stall.
`include "assert_macros.svh"

module rgb_to_hsv_pixel_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rthsv_pkg::pix_req_t req_i,
  output logic                done_o,
  output rthsv_pkg::hsv_rsp_t rsp_o
);

  logic              vld [rthsv_pkg::NumCells+1];
  rthsv_pkg::stage_t stg [rthsv_pkg::NumCells+1];

  assign busy = 1'b0;

  rthsv_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start),
    .pix_i  (req_i),
    .valid_o(vld[0]),
    .stg_o  (stg[0])
  );

  for (genvar i = 0; i < rthsv_pkg::NumCells; i++) begin : g_cell
    rthsv_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[i]),
      .stg_i  (stg[i]),
      .valid_o(vld[i+1]),
      .stg_o  (stg[i+1])
    );
  end

  assign done_o           = vld[rthsv_pkg::NumCells];
  assign rsp_o.hue        = stg[rthsv_pkg::NumCells].hue.sh;
  assign rsp_o.saturation = rthsv_pkg::ChMax
                            - stg[rthsv_pkg::NumCells].sat.sh[rthsv_pkg::ChW-1:0];
  assign rsp_o.brightness = stg[rthsv_pkg::NumCells].brightness;

  `ASSERT_IMPL(a_done_lat, done_o, $past(start, rthsv_pkg::Latency), "result without request")
  `ASSERT_IMPL(a_black, done_o && rsp_o.brightness == '0,
               rsp_o.saturation == '0 && rsp_o.hue == '0, "black pixel not zero")
  `ASSERT_IMPL(a_rem_lt_dvs, vld[1],
               stg[1].hue.rem < stg[1].hue.dvs && stg[1].sat.rem < stg[1].sat.dvs,
               "divider remainder out of range")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseLen   = 190;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  rthsv_pkg::pix_req_t pix_req = '0;
  logic                busy;
  logic                done;
  rthsv_pkg::hsv_rsp_t hsv_rsp;

  rthsv_pkg::pix_req_t pix_q[$];
  rthsv_pkg::hsv_rsp_t hsv_q[$];
  rthsv_pkg::hsv_rsp_t want_hsv;
  int unsigned         idle_pct = 0;
  int                  err_cnt = 0;
  int                  n_done = 0;
  int                  n_grey = 0;
  int                  n_tie = 0;
  int                  idle_cycles = 0;

  rgb_to_hsv_pixel_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (pix_req),
    .done_o (done),
    .rsp_o  (hsv_rsp)
  );

  function automatic rthsv_pkg::hsv_rsp_t predict_hsv(rthsv_pkg::pix_req_t p);
    int                  r, g, b, mx, mn, d, ofs, dif;
    rthsv_pkg::hsv_rsp_t o;
    r  = p.red_in;
    g  = p.green_in;
    b  = p.blue_in;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    o.brightness = rthsv_pkg::ChW'(mx);
    if (mx == 0) begin
      o.saturation = '0;
    end else begin
      o.saturation = rthsv_pkg::ChW'(int'(rthsv_pkg::ChMax)
                     - (int'(rthsv_pkg::ChMax) * mn + mx - 1) / mx);
    end
    if (mx == mn) begin
      o.hue = '0;
    end else begin
      d = mx - mn;
      if (mx == r && g >= b) begin
        ofs = 0;
        dif = g - b;
      end else if (mx == r) begin
        ofs = int'(rthsv_pkg::HueOffRedNeg);
        dif = g - b;
      end else if (mx == g) begin
        ofs = int'(rthsv_pkg::HueOffGreen);
        dif = b - r;
      end else begin
        ofs = int'(rthsv_pkg::HueOffBlue);
        dif = r - g;
      end
      o.hue = rthsv_pkg::HueW'((ofs * d + int'(rthsv_pkg::HueScale) * dif) / d);
    end
    return o;
  endfunction

  // biased toward grey, pairs of equal channels, extremes and narrow spreads
  function automatic rthsv_pkg::pix_req_t rand_pixel();
    rthsv_pkg::pix_req_t p;
    int unsigned         base;
    p.red_in   = rthsv_pkg::ChW'($urandom);
    p.green_in = rthsv_pkg::ChW'($urandom);
    p.blue_in  = rthsv_pkg::ChW'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        p.green_in = p.red_in;
        p.blue_in  = p.red_in;
      end
      1: p.green_in = p.red_in;
      2: p.blue_in = p.green_in;
      3: p.blue_in = p.red_in;
      4: begin
        if ($urandom_range(1)) p.red_in = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(1)) p.green_in = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(1)) p.blue_in = $urandom_range(1) ? 8'hff : 8'h00;
      end
      5: begin
        base       = $urandom_range(0, 250);
        p.red_in   = rthsv_pkg::ChW'(base + $urandom_range(0, 5));
        p.green_in = rthsv_pkg::ChW'(base + $urandom_range(0, 5));
        p.blue_in  = rthsv_pkg::ChW'(base + $urandom_range(0, 5));
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      pix_req <= '0;
    end else if (!start || !busy) begin
      if (pix_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        pix_req <= pix_q.pop_front();
      end else begin
        start   <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if (start && !busy) begin
        hsv_q.push_back(predict_hsv(pix_req));
        if (pix_req.red_in == pix_req.green_in && pix_req.green_in == pix_req.blue_in) begin
          n_grey++;
        end else if (pix_req.red_in == pix_req.green_in || pix_req.green_in == pix_req.blue_in
                     || pix_req.red_in == pix_req.blue_in) begin
          n_tie++;
        end
      end
      if (done) begin
        if (hsv_q.size() == 0) begin
          $error("result with no request outstanding: hue %0d sat %0d val %0d",
                 hsv_rsp.hue, hsv_rsp.saturation, hsv_rsp.brightness);
          err_cnt++;
        end else begin
          want_hsv = hsv_q.pop_front();
          n_done++;
          if (hsv_rsp.hue !== want_hsv.hue) begin
            $error("hue: expected %0d, got %0d", want_hsv.hue, hsv_rsp.hue);
            err_cnt++;
          end
          if (hsv_rsp.saturation !== want_hsv.saturation) begin
            $error("saturation: expected %0d, got %0d", want_hsv.saturation,
                   hsv_rsp.saturation);
            err_cnt++;
          end
          if (hsv_rsp.brightness !== want_hsv.brightness) begin
            $error("brightness: expected %0d, got %0d", want_hsv.brightness,
                   hsv_rsp.brightness);
            err_cnt++;
          end
        end
      end
      if ((start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d requests still outstanding", hsv_q.size());
        $display("** rgb_to_hsv_pixel_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_idle[4];
    phase_idle = '{0, 47, 0, 24};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // black, white, grey, primaries, secondaries with tied maxima, wrap near 360
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd0, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd255, 8'd255});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd128, 8'd128, 8'd128});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd1, 8'd1, 8'd1});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd0, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd255, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd0, 8'd255});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd255, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd255, 8'd255});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd0, 8'd255});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd0, 8'd1});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd1, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd1, 8'd0, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd1, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd0, 8'd0, 8'd1});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd254, 8'd255, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd255, 8'd254, 8'd253});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd10, 8'd20, 8'd30});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd200, 8'd100, 8'd50});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd1, 8'd1, 8'd0});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd85, 8'd170, 8'd255});
    pix_q.push_back(rthsv_pkg::pix_req_t'{8'd170, 8'd85, 8'd15});

    foreach (phase_idle[i]) begin
      while (pix_q.size() != 0 || start || hsv_q.size() != 0) @(negedge clk_i);
      idle_pct = phase_idle[i];
      repeat (PhaseLen) pix_q.push_back(rand_pixel());
    end

    while (pix_q.size() != 0 || start || hsv_q.size() != 0) @(negedge clk_i);
    repeat (rthsv_pkg::Latency + 5) @(negedge clk_i);

    $display("%0d pixels converted and checked, %0d grey and %0d with two equal channels,",
             n_done, n_grey, n_tie);
    $display("with the source idling at 0, 47 and 24 percent and a drain between phases");
    if (err_cnt == 0) begin
      $display("** rgb_to_hsv_pixel_unit: PASSED **");
    end else begin
      $display("** rgb_to_hsv_pixel_unit: FAILED **");
    end
    $finish;
  end

endmodule
